// ===== hw/rtl/ordered_list_engine_assert.svh =====
// ----------------------------------------------------------------------------
// ordered_list_engine_assert
// Assertion macros used by the checker of the ordered list engine.
// ----------------------------------------------------------------------------
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, muted during reset
`define OLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted during reset
`define OLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ole_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ole_pkg
// Opcodes, cell control and scan result types shared by the list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INSERT_AT  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_REMOVE_AT  = 3'd5,
    OP_SEARCH     = 3'd6
  } op_e;

  // Reported position when nothing was found or the request is no search
  localparam logic [6:0] NO_POSITION = 7'h7F;

  // Compare flags examined by the scanner per cycle
  localparam int unsigned GROUP_W = 8;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic do_insert;
    logic do_remove;
    logic do_compare;
  } cell_ctrl_t;

  // Scanner outcome, valid while done is high
  typedef struct packed {
    logic       done;
    logic       hit;
    logic [6:0] pos;
  } scan_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ole_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ole_cell
// One list slot: holds an entry, shifts toward the back on insert and
// toward the front on remove, and latches its compare flag on search.
// ----------------------------------------------------------------------------
module ole_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7
) (
  input  wire                    clk_i,
  input  wire ole_pkg::cell_ctrl_t ctrl_i,
  input  wire  [CW-1:0]          pos_i,
  input  wire  [CW-1:0]          count_i,
  input  wire  [31:0]            value_i,
  input  wire  [31:0]            left_i,
  input  wire  [31:0]            right_i,
  output logic [31:0]            data_o,
  output logic                   match_o
);
  import ole_pkg::*;

  localparam logic [CW-1:0] IdxC = CW'(IDX);

  logic [31:0] data_q, data_d;
  logic        match_q, match_d;

  // Pick the entry for the next cycle
  always_comb begin
    data_d  = data_q;
    match_d = match_q;
    if (ctrl_i.do_insert) begin
      if (IdxC > pos_i) begin
        data_d = left_i;
      end else if (IdxC == pos_i) begin
        data_d = value_i;
      end
    end else if (ctrl_i.do_remove) begin
      if (IdxC >= pos_i) begin
        data_d = right_i;
      end
    end
    if (ctrl_i.do_compare) begin
      match_d = (IdxC < count_i) && (data_q == value_i);
    end
  end

  always_ff @(posedge clk_i) begin
    data_q  <= data_d;
    match_q <= match_d;
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ole_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ole_scan
// First-match finder: walks the latched compare flags one group per cycle
// and stops at the first group that holds a match or at the last group.
// ----------------------------------------------------------------------------
module ole_scan #(
  parameter int unsigned DEPTH = 64
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  wire  [DEPTH-1:0]    match_i,
  output ole_pkg::scan_res_t  res_o
);
  import ole_pkg::*;

  localparam int unsigned NumGrp = (DEPTH + GROUP_W - 1) / GROUP_W;
  localparam int unsigned GW     = (NumGrp > 1) ? $clog2(NumGrp) : 1;
  localparam int unsigned EW     = $clog2(GROUP_W);
  localparam int unsigned PadW   = NumGrp * GROUP_W;
  localparam logic [GW-1:0] LastGrp = GW'(NumGrp - 1);

  logic [PadW-1:0]    padded;
  logic [GROUP_W-1:0] grp_bits;
  logic [EW-1:0]      enc;
  logic               busy_q;
  logic [GW-1:0]      grp_q;
  logic               done;

  assign padded   = PadW'(match_i);
  assign grp_bits = padded[{grp_q, EW'(0)} +: GROUP_W];

  // Lowest set flag of the current group
  always_comb begin
    enc = '0;
    for (int b = GROUP_W - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        enc = EW'(b);
      end
    end
  end

  assign done = busy_q && ((|grp_bits) || (grp_q == LastGrp));

  // Advance through the groups
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      grp_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      grp_q  <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      grp_q <= grp_q + GW'(1);
    end
  end

  assign res_o.done = done;
  assign res_o.hit  = |grp_bits;
  assign res_o.pos  = 7'({grp_q, enc});

endmodule
`default_nettype wire

// ===== hw/rtl/ordered_list_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of signed 32-bit values kept in a shifting chain of cells.
// ----------------------------------------------------------------------------
// Each request is one list operation. Push, insert, pop and remove finish in
// the cycle they are accepted: the cells at and behind the position shift
// toward the back or the front at once (pop back only lowers the count), and
// one request per cycle is taken while the result register drains. A search
// latches a compare flag in every cell in the accept cycle, then a scanner
// reads eight flags per cycle, at most ceil(DEPTH/8) groups, until the first
// match; no new request is taken meanwhile. Positions and counts on the ports
// are 7 bits wide.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  [2:0]         opcode_i,
  input  wire  signed [31:0] value_i,
  input  wire  [6:0]         position_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic               ok_o,
  output logic signed [6:0]  found_position_o,
  output logic [6:0]         entry_count_o
);
  import ole_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CW   = (CntW > 7) ? CntW : 7;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic            ok_q;
  logic [6:0]      found_q;
  logic [6:0]      cnt_out_q;

  logic            accept;
  logic            full;
  logic            load_now;
  logic            start_scan;
  logic            ok_d;
  logic [CW-1:0]   pos_c;
  logic [CW-1:0]   cnt_c;
  logic [CW-1:0]   op_pos;
  cell_ctrl_t      ctrl;
  scan_res_t       scan_res;

  logic [31:0]      cell_data [DEPTH];
  logic [DEPTH-1:0] match;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign full       = (count_q == CntW'(DEPTH));
  assign pos_c      = CW'(position_i);
  assign cnt_c      = CW'(count_q);

  // Decode the request into cell control and the new count
  always_comb begin
    ctrl       = '0;
    op_pos     = '0;
    ok_d       = 1'b0;
    count_d    = count_q;
    load_now   = 1'b0;
    start_scan = 1'b0;
    if (accept) begin
      load_now = 1'b1;
      case (opcode_i)
        OP_PUSH_FRONT: begin
          if (!full) begin
            ctrl.do_insert = 1'b1;
            count_d        = count_q + CntW'(1);
            ok_d           = 1'b1;
          end
        end
        OP_PUSH_BACK: begin
          if (!full) begin
            ctrl.do_insert = 1'b1;
            op_pos         = cnt_c;
            count_d        = count_q + CntW'(1);
            ok_d           = 1'b1;
          end
        end
        OP_INSERT_AT: begin
          if (!full && (pos_c <= cnt_c)) begin
            ctrl.do_insert = 1'b1;
            op_pos         = pos_c;
            count_d        = count_q + CntW'(1);
            ok_d           = 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (count_q != '0) begin
            ctrl.do_remove = 1'b1;
            count_d        = count_q - CntW'(1);
            ok_d           = 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (count_q != '0) begin
            count_d = count_q - CntW'(1);
            ok_d    = 1'b1;
          end
        end
        OP_REMOVE_AT: begin
          if (pos_c < cnt_c) begin
            ctrl.do_remove = 1'b1;
            op_pos         = pos_c;
            count_d        = count_q - CntW'(1);
            ok_d           = 1'b1;
          end
        end
        OP_SEARCH: begin
          ctrl.do_compare = 1'b1;
          start_scan      = 1'b1;
          load_now        = 1'b0;
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end
  end

  // Hold in scan until the first match is known
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_scan) state_d = ST_SCAN;
      ST_SCAN: if (scan_res.done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load_now || scan_res.done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (load_now) begin
      ok_q      <= ok_d;
      found_q   <= NO_POSITION;
      cnt_out_q <= 7'(count_d);
    end else if (scan_res.done) begin
      ok_q      <= 1'b1;
      found_q   <= scan_res.hit ? scan_res.pos : NO_POSITION;
      cnt_out_q <= 7'(count_q);
    end
  end

  // Chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] left_data;
    logic [31:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_mid
      assign left_data = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end
    ole_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (op_pos),
      .count_i (cnt_c),
      .value_i (value_i),
      .left_i  (left_data),
      .right_i (right_data),
      .data_o  (cell_data[i]),
      .match_o (match[i])
    );
  end

  ole_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_scan),
    .match_i (match),
    .res_o   (scan_res)
  );

  assign out_valid_o      = out_valid_q;
  assign ok_o             = ok_q;
  assign found_position_o = found_q;
  assign entry_count_o    = cnt_out_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ole_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ole_checker
// Port-level checks of the ordered list engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "ordered_list_engine_assert.svh"

module ole_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_ready_o,
  input wire               out_valid_o,
  input wire               out_ready_i,
  input wire               ok_o,
  input wire  signed [6:0] found_position_o,
  input wire  [6:0]        entry_count_o
);
  import ole_pkg::*;

  // A stalled result holds its fields
  `OLE_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(ok_o) && $stable(found_position_o) && $stable(entry_count_o), "result changed while stalled")

  // A found position only comes from a search, which always succeeds
  `OLE_ASSERT_IMP(a_found_ok, out_valid_o && (found_position_o != NO_POSITION), ok_o, "found position reported without success")

  // A new request is taken only when the pending result leaves
  `OLE_ASSERT_IMP(a_no_overrun, in_ready_o && out_valid_o, out_ready_i, "request taken over a pending result")

endmodule

bind ordered_list_engine ole_checker u_ole_checker (.*);
`default_nettype wire
